// ----- hw/rtl/sdn_pkg.sv -----
// ============================================================================
// sdn_pkg: shared types, constants and scale tables for the degree-to-note block
// Holds the fixed scale tables, configuration register indexes and the
// control word that travels down the pipeline.
// ============================================================================
package sdn_pkg;

  localparam int SCALE_COUNT = 13;
  localparam int MAX_STEPS   = 12;
  localparam int DIV_BITS    = 4;   // dividend bits consumed per divider stage
  localparam int CFG_IDX_W   = 2;
  localparam int ROOT_W      = 7;
  localparam int SEL_W       = 4;
  localparam int NOTE_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NOTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SELECT = 2'd1;

  localparam logic [ROOT_W-1:0] ROOT_RESET = 7'd60;
  localparam logic [SEL_W-1:0]  SEL_RESET  = 4'd0;
  localparam logic [SEL_W-1:0]  SEL_MAJOR  = 4'd0;
  localparam logic [ROOT_W-1:0] NOTE_CAP   = 7'd127;

  // Step count of each scale
  localparam logic [3:0] SCALE_LEN [SCALE_COUNT] = '{
    4'd7, 4'd7, 4'd12, 4'd7, 4'd7, 4'd8, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd8, 4'd5
  };

  // Interval of each step above the root; the last used entry is the octave
  localparam logic [3:0] SCALE_TAB [SCALE_COUNT][MAX_STEPS] = '{
    '{4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12},
    '{4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd4, 4'd7, 4'd9, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd5, 4'd7, 4'd10, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd7, 4'd9, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9, 4'd11, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd7, 4'd8, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  // Control word carried alongside the dividend
  typedef struct packed {
    logic              neg;    // degree was negative
    logic [SEL_W-1:0]  sel;    // resolved scale, 0..12
    logic [3:0]        steps;  // step count of that scale
    logic [ROOT_W-1:0] root;   // root note
    logic [3:0]        rem;    // running remainder
    logic [3:0]        quo;    // running quotient, saturated at 15
  } sdn_ctl_t;

  function automatic logic [SEL_W-1:0] scale_fix(input logic [SEL_W-1:0] sel);
    return (sel < SEL_W'(SCALE_COUNT)) ? sel : SEL_MAJOR;
  endfunction

  function automatic logic [3:0] scale_steps(input logic [SEL_W-1:0] sel);
    return SCALE_LEN[sel];
  endfunction

  function automatic logic [3:0] scale_iv(input logic [SEL_W-1:0] sel,
                                          input logic [3:0] idx);
    return SCALE_TAB[sel][idx];
  endfunction

endpackage

// ----- hw/rtl/sdn_front.sv -----
// ============================================================================
// sdn_front: input stage
// Registers the degree as sign plus magnitude and looks up the step count.
// ============================================================================
module sdn_front #(
  parameter int DEGREE_WIDTH = 16,
  parameter int PAD_WIDTH    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic [DEGREE_WIDTH-1:0]  up_degree,
  input  logic [sdn_pkg::ROOT_W-1:0] cfg_root,
  input  logic [sdn_pkg::SEL_W-1:0]  cfg_sel,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output sdn_pkg::sdn_ctl_t        dn_ctl,
  output logic [PAD_WIDTH-1:0]     dn_val
);
  import sdn_pkg::*;

  logic                    v_r;
  sdn_ctl_t                ctl_r, ctl_nxt;
  logic [PAD_WIDTH-1:0]    val_r, val_nxt;
  logic [DEGREE_WIDTH-1:0] mag;
  logic [SEL_W-1:0]        sel_fix;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    sel_fix = scale_fix(cfg_sel);
    // magnitude fits in DEGREE_WIDTH bits, even for the most negative value
    mag     = up_degree[DEGREE_WIDTH-1] ? (~up_degree + 1'b1) : up_degree;
    val_nxt = PAD_WIDTH'(mag);
    ctl_nxt.neg   = up_degree[DEGREE_WIDTH-1];
    ctl_nxt.sel   = sel_fix;
    ctl_nxt.steps = scale_steps(sel_fix);
    ctl_nxt.root  = cfg_root;
    ctl_nxt.rem   = 4'd0;
    ctl_nxt.quo   = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      ctl_r <= ctl_nxt;
      val_r <= val_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_ctl   = ctl_r;
  assign dn_val   = val_r;

endmodule

// ----- hw/rtl/sdn_div_stage.sv -----
// ============================================================================
// sdn_div_stage: one stage of the pipelined divider
// Shifts DIV_BITS dividend bits into the remainder by restoring division
// against the scale's step count and keeps a saturated quotient.
// ============================================================================
module sdn_div_stage #(
  parameter int PAD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  sdn_pkg::sdn_ctl_t    up_ctl,
  input  logic [PAD_WIDTH-1:0] up_val,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sdn_pkg::sdn_ctl_t    dn_ctl,
  output logic [PAD_WIDTH-1:0] dn_val
);
  import sdn_pkg::*;

  logic                 v_r;
  sdn_ctl_t             ctl_r, ctl_nxt;
  logic [PAD_WIDTH-1:0] val_r, val_nxt;
  logic [4:0]           trial;
  logic [4:0]           qx;
  logic                 qb;
  logic [3:0]           rem;
  logic [3:0]           quo;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    rem   = up_ctl.rem;
    quo   = up_ctl.quo;
    trial = 5'd0;
    qx    = 5'd0;
    qb    = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem, up_val[PAD_WIDTH-1-i]};
      qb    = (trial >= {1'b0, up_ctl.steps});
      if (qb) begin
        trial = trial - {1'b0, up_ctl.steps};
      end
      rem = trial[3:0];
      qx  = {quo, qb};
      quo = (qx > 5'd15) ? 4'd15 : qx[3:0];
    end
    ctl_nxt     = up_ctl;
    ctl_nxt.rem = rem;
    ctl_nxt.quo = quo;
    val_nxt     = up_val << DIV_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      ctl_r <= ctl_nxt;
      val_r <= val_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_ctl   = ctl_r;
  assign dn_val   = val_r;

endmodule

// ----- hw/rtl/sdn_back.sv -----
// ============================================================================
// sdn_back: note assembly and output register
// Turns quotient and remainder into octave offset, step interval and the
// lowered root, and holds the finished note for the result channel.
// ============================================================================
module sdn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  sdn_pkg::sdn_ctl_t           up_ctl,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [sdn_pkg::NOTE_W-1:0]  dn_note
);
  import sdn_pkg::*;

  logic                v_r;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic [3:0]          last_iv;
  logic [4:0]          qp1;
  logic [8:0]          drop;
  logic [ROOT_W-1:0]   root_adj;
  logic [3:0]          base_q;
  logic [3:0]          base_r;
  logic [7:0]          prod;
  logic [ROOT_W-1:0]   base;
  logic [3:0]          iv;
  logic [ROOT_W-1:0]   room;
  logic [ROOT_W-1:0]   add;
  logic [ROOT_W-1:0]   offset;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    last_iv = scale_iv(up_ctl.sel, up_ctl.steps - 4'd1);
    qp1     = {1'b0, up_ctl.quo} + 5'd1;
    drop    = {5'd0, last_iv} * {4'd0, qp1};
    if (up_ctl.neg) begin
      // lower the root by whole octaves, floor at zero; remainder counts up
      root_adj = (drop < {2'b0, up_ctl.root}) ? ROOT_W'({2'b0, up_ctl.root} - drop)
                                              : '0;
      base_q   = (up_ctl.rem == 4'd0) ? 4'd1 : 4'd0;
      base_r   = (up_ctl.rem == 4'd0) ? 4'd0 : (up_ctl.steps - up_ctl.rem);
    end else begin
      root_adj = up_ctl.root;
      base_q   = up_ctl.quo;
      base_r   = up_ctl.rem;
    end
    prod   = {4'd0, last_iv} * {4'd0, base_q};
    base   = (prod > {1'b0, NOTE_CAP}) ? NOTE_CAP : prod[ROOT_W-1:0];
    iv     = (base_r != 4'd0) ? scale_iv(up_ctl.sel, base_r - 4'd1) : 4'd0;
    room   = NOTE_CAP - base;
    add    = ({3'd0, iv} < room) ? {3'd0, iv} : room;
    offset = base + add;
    note_nxt = {1'b0, root_adj} + {1'b0, offset};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      note_r <= note_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_note  = note_r;

endmodule

// ----- hw/rtl/scale_degree_to_note.sv -----
// ============================================================================
// scale_degree_to_note: scale degree to MIDI note number
// Maps a signed scale degree onto one of thirteen fixed scales above a
// configurable root note.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | in_degree (signed degree)
//  out     | output    | out_valid / out_ready| out_note (0..254)
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
//  One transaction in, one transaction out, one per cycle sustained while
//  out_ready is high. The pipeline has an input stage, ceil(DEGREE_WIDTH / 4)
//  divider stages of four restoring steps each, and the note assembly stage,
//  which is also the output register.
//  Reset is synchronous and active low; it clears all stage valid bits and
//  loads root note 60 and the major scale.
//  A stall holds each occupied stage whose later stages are all full; the rest
//  keep filling, so bubbles collapse and no transaction is lost or repeated.
//
module scale_degree_to_note #(
  parameter int DEGREE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [sdn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdn_pkg::ROOT_W-1:0]      cfg_wdata,
  // degree input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [DEGREE_WIDTH-1:0]  in_degree,
  // note output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdn_pkg::NOTE_W-1:0]      out_note
);
  import sdn_pkg::*;

  localparam int DIV_STAGES = (DEGREE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_WIDTH  = DIV_STAGES * DIV_BITS;

  // configuration registers
  logic [ROOT_W-1:0] root_note_r;
  logic [SEL_W-1:0]  scale_select_r;

  // pipeline links: index k is the output of the front stage (k = 0) or of
  // divider stage k
  logic                 vld [DIV_STAGES+1];
  logic                 rdy [DIV_STAGES+1];
  sdn_ctl_t             ctl [DIV_STAGES+1];
  logic [PAD_WIDTH-1:0] val [DIV_STAGES+1];

  // Write the addressed register; drop writes to unused indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_note_r    <= ROOT_RESET;
      scale_select_r <= SEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT_NOTE: begin
          root_note_r <= cfg_wdata;
        end
        CFG_SCALE_SELECT: begin
          scale_select_r <= cfg_wdata[SEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Split the degree into sign and magnitude, resolve the scale.
  sdn_front #(
    .DEGREE_WIDTH (DEGREE_WIDTH),
    .PAD_WIDTH    (PAD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_degree (in_degree),
    .cfg_root  (root_note_r),
    .cfg_sel   (scale_select_r),
    .dn_valid  (vld[0]),
    .dn_ready  (rdy[0]),
    .dn_ctl    (ctl[0]),
    .dn_val    (val[0])
  );

  // Divide the magnitude by the step count, four bits per stage.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    sdn_div_stage #(
      .PAD_WIDTH (PAD_WIDTH)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_ctl   (ctl[k]),
      .up_val   (val[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_ctl   (ctl[k+1]),
      .dn_val   (val[k+1])
    );
  end

  // Assemble the note and hold it until the consumer takes it.
  sdn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[DIV_STAGES]),
    .up_ready (rdy[DIV_STAGES]),
    .up_ctl   (ctl[DIV_STAGES]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_note  (out_note)
  );

  // The dividend has been fully shifted out by the last stage.
  logic unused_tail;
  assign unused_tail = ^val[DIV_STAGES];

endmodule

// ----- hw/rtl/sdn_checker.sv -----
// ============================================================================
// sdn_checker: port-level checks for scale_degree_to_note
// Watches the result channel and the stall path over time.
// ============================================================================
module sdn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sdn_pkg::NOTE_W-1:0]  out_note
);
  import sdn_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_note))
    else $error("result changed or dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A free output lets every stage advance, so the input is never blocked.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // Root plus capped offset never exceeds 254.
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_note <= 8'd254)
    else $error("note out of range");

endmodule

bind scale_degree_to_note sdn_checker u_sdn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_note  (out_note)
);
